>>> src/bounded_stack_palindrome_check_macros.svh
`ifndef BOUNDED_STACK_PALINDROME_CHECK_MACROS_SVH
`define BOUNDED_STACK_PALINDROME_CHECK_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bspc assertion failed");

// next-cycle implication
`define BSPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bspc assertion failed");

`endif

>>> src/bspc_pkg.sv
package bspc_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_OVF,
    KIND_UND
  } kind_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [3:0]         fill_count;
    logic               is_palindrome;
  } out_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } cls_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

>>> src/bspc_queue.sv
module bspc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bspc_pkg::cls_t   push_item,
  input  logic             pop,
  output bspc_pkg::cls_t   head_item,
  output bspc_pkg::q_stat_t stat
);
  import bspc_pkg::*;

  cls_t       slots_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head_item  = slots_r[rd_ptr_r];
  assign stat.valid = (cnt_r != 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/bspc_front.sv
module bspc_front #(
  parameter int STACK_DEPTH = 8,
  parameter int CW          = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bspc_pkg::in_t     in_data,
  output logic              busy,
  input  bspc_pkg::q_stat_t q_stat,
  output logic              q_push,
  output bspc_pkg::cls_t    q_item
);
  import bspc_pkg::*;

  logic [CW-1:0] cnt_r, cnt_nxt;

  assign busy   = q_stat.full;
  assign q_push = start && !q_stat.full;

  always_comb begin
    cnt_nxt      = cnt_r;
    q_item.value = in_data.push_value;
    if (in_data.req_type == REQ_PUSH) begin
      if (cnt_r >= CW'(STACK_DEPTH)) begin
        q_item.kind = KIND_OVF;
      end else begin
        q_item.kind = KIND_PUSH;
        cnt_nxt     = cnt_r + CW'(1);
      end
    end else begin
      if (cnt_r == '0) begin
        q_item.kind = KIND_UND;
      end else begin
        q_item.kind = KIND_POP;
        cnt_nxt     = cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (q_push) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> src/bspc_back.sv
`include "bounded_stack_palindrome_check_macros.svh"

module bspc_back #(
  parameter int STACK_DEPTH = 8,
  parameter int AW          = 3,
  parameter int CW          = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bspc_pkg::q_stat_t q_stat,
  input  bspc_pkg::cls_t    q_item,
  output logic              q_pop,
  output logic              out_valid,
  output bspc_pkg::out_t    out_data
);
  import bspc_pkg::*;

  typedef enum logic {S_IDLE, S_CHECK} state_t;

  logic signed [31:0] mem [STACK_DEPTH];

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      lo_r, lo_nxt;
  logic [AW-1:0]      hi_r, hi_nxt;
  logic               pend_r, pend_nxt;
  logic               pal_r, pal_nxt;
  kind_t              kind_r, kind_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic signed [31:0] rd_a_r, rd_b_r, rd_pop_r;

  logic               take, issue, mismatch, done;
  logic [CW-1:0]      cnt_take, cnt_dec, pop_dec;
  logic [AW-1:0]      hi_start;

  assign take     = (state_r == S_IDLE) && q_stat.valid;
  assign q_pop    = take;
  assign issue    = (state_r == S_CHECK) && (lo_r < hi_r);
  assign mismatch = pend_r && (rd_a_r != rd_b_r);
  assign done     = (state_r == S_CHECK) && !issue && !pend_r;
  assign cnt_dec  = cnt_take - CW'(1);
  assign pop_dec  = cnt_r - CW'(1);
  assign hi_start = (cnt_take == '0) ? '0 : cnt_dec[AW-1:0];

  always_comb begin
    case (q_item.kind)
      KIND_PUSH: cnt_take = cnt_r + CW'(1);
      KIND_POP:  cnt_take = cnt_r - CW'(1);
      default:   cnt_take = cnt_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    pend_nxt  = 1'b0;
    pal_nxt   = pal_r;
    kind_nxt  = kind_r;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_CHECK;
          cnt_nxt   = cnt_take;
          lo_nxt    = '0;
          hi_nxt    = hi_start;
          pal_nxt   = 1'b1;
          kind_nxt  = q_item.kind;
        end
      end
      S_CHECK: begin
        pend_nxt = issue;
        if (issue) begin
          lo_nxt = lo_r + AW'(1);
          hi_nxt = hi_r - AW'(1);
        end
        if (mismatch) begin
          pal_nxt = 1'b0;
        end
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt              = done;
    out_data_nxt.popped_value  = '0;
    out_data_nxt.fill_count    = 4'(cnt_r);
    out_data_nxt.is_palindrome = pal_r;
    case (kind_r)
      KIND_OVF: out_data_nxt.status = ST_OVERFLOW;
      KIND_UND: out_data_nxt.status = ST_UNDERFLOW;
      KIND_POP: begin
        out_data_nxt.status       = ST_OK;
        out_data_nxt.popped_value = rd_pop_r;
      end
      default:  out_data_nxt.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    pal_r  <= pal_nxt;
    kind_r <= kind_nxt;
    if (done) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.kind == KIND_PUSH) begin
      mem[cnt_r[AW-1:0]] <= q_item.value;
    end
    if (take && q_item.kind == KIND_POP) begin
      rd_pop_r <= mem[pop_dec[AW-1:0]];
    end
    if (issue) begin
      rd_a_r <= mem[lo_r];
      rd_b_r <= mem[hi_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BSPC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `BSPC_ASSERT_NEXT(a_strobe_single, out_valid_r, !out_valid_r)
  `BSPC_ASSERT_IMPL(a_fail_no_pop, out_valid_r && out_data_r.status != ST_OK, out_data_r.popped_value == '0)
  `BSPC_ASSERT_IMPL(a_short_pal, out_valid_r && cnt_r < CW'(2), out_data_r.is_palindrome)

endmodule

>>> src/bounded_stack_palindrome_check.sv
// Bounded LIFO stack of signed 32-bit words with a mirror-symmetry check.
// Input channel: in_data (req_type push/pop, push_value) is taken at a rising
// edge with start high and busy low. busy is high while the two-entry
// transaction queue between the classifier and the executor is full.
// Result channel: out_valid strobes for exactly one cycle with out_data
// (status, popped_value, fill_count, is_palindrome). The receiver cannot
// stall; every transaction yields exactly one result, in order.
// The executor handles one transaction at a time: it takes it from the
// queue, compares the P = floor(fill/2) mirrored pairs after the operation
// one after another through the two read ports of the stack memory, folds
// in the last compare and registers the result. It takes the next one from
// the queue only once that check is done; up to two transactions wait in
// the queue meanwhile.
// Reset (rst_n low, synchronous): stack empty, queue empty, no strobe.
// Stack contents are not cleared; only written entries are ever read.
module bounded_stack_palindrome_check #(
  parameter int STACK_DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bspc_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_valid,
  output bspc_pkg::out_t out_data
);
  import bspc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  cls_t    q_in, q_out;

  bspc_front #(
    .STACK_DEPTH(STACK_DEPTH),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .in_data(in_data),
    .busy(busy),
    .q_stat(q_stat),
    .q_push(q_push),
    .q_item(q_in)
  );

  bspc_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .push_item(q_in),
    .pop(q_pop),
    .head_item(q_out),
    .stat(q_stat)
  );

  bspc_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_stat(q_stat),
    .q_item(q_out),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_data(out_data)
  );

endmodule

>>> bench/tb_bounded_stack_palindrome_check.sv
module tb_bounded_stack_palindrome_check;
  timeunit 1ns;
  timeprecision 1ps;

  import bspc_pkg::*;

  localparam int DEPTH       = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  logic start;
  in_t  in_data;
  logic busy;
  logic out_valid;
  out_t out_data;

  bounded_stack_palindrome_check #(.STACK_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // stack mirror kept by the testbench
  logic signed [31:0] stack_words [DEPTH];
  int                 stack_fill;
  out_t               pending_results[$];

  int fail_count;
  int cycle_count;
  int burst_left;
  int n_push, n_pop, n_overflow, n_underflow, n_mirror;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic mirror_match();
    int lo;
    int hi;
    lo = 0;
    hi = stack_fill - 1;
    while (lo < hi) begin
      if (stack_words[lo] != stack_words[hi]) return 1'b0;
      lo++;
      hi--;
    end
    return 1'b1;
  endfunction

  function automatic out_t apply_request(in_t item);
    out_t r;
    r = '0;
    r.status = ST_OK;
    if (item.req_type == REQ_PUSH) begin
      if (stack_fill >= DEPTH) begin
        r.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        stack_words[stack_fill] = item.push_value;
        stack_fill++;
        n_push++;
      end
    end else begin
      if (stack_fill == 0) begin
        r.status = ST_UNDERFLOW;
        n_underflow++;
      end else begin
        stack_fill--;
        r.popped_value = stack_words[stack_fill];
        n_pop++;
      end
    end
    r.fill_count    = stack_fill[3:0];
    r.is_palindrome = mirror_match();
    if (r.is_palindrome && stack_fill > 1) n_mirror++;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -32'sd1;
      4:       return 32'sd5;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic kind, input logic signed [31:0] word);
    in_t item;
    item.req_type   = kind;
    item.push_value = word;
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(item));
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 8);
    end
  endtask

  task automatic idle_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_pop_empty();
    send_request(REQ_POP, WORD_MAX);
  endtask

  // fills to a symmetric stack through the word extremes
  task automatic test_fill_mirror();
    logic signed [31:0] seq [4];
    seq = '{WORD_MIN, WORD_MAX, -32'sd1, 32'sd5};
    for (int i = 0; i < 4; i++) send_request(REQ_PUSH, seq[i]);
    for (int i = 3; i >= 0; i--) send_request(REQ_PUSH, seq[i]);
  endtask

  task automatic test_push_full();
    send_request(REQ_PUSH, '0);
    send_request(REQ_PUSH, -32'sd1);
  endtask

  task automatic test_drain();
    for (int i = 0; i <= DEPTH; i++) send_request(REQ_POP, $urandom);
  endtask

  // empties the stack, then pushes symmetric sequences, some with one bit flipped, some with an extra word on top
  task automatic test_mirror_blocks(input int blocks);
    logic signed [31:0] seq [DEPTH];
    int len;
    int idx;
    for (int b = 0; b < blocks; b++) begin
      while (stack_fill > 0) begin
        send_request(REQ_POP, $urandom);
        pace();
      end
      len = $urandom_range(1, DEPTH);
      for (int i = 0; i < len; i++)
        seq[i] = (i < (len + 1) / 2) ? pick_word() : seq[len - 1 - i];
      if ($urandom_range(0, 3) == 0) begin
        idx = $urandom_range(0, len - 1);
        seq[idx] = seq[idx] ^ (32'sd1 <<< $urandom_range(0, 31));
      end
      for (int i = 0; i < len; i++) begin
        send_request(REQ_PUSH, seq[i]);
        pace();
      end
      if ($urandom_range(0, 1) == 0) begin
        send_request(REQ_PUSH, pick_word());
        pace();
      end
    end
  endtask

  task automatic test_random_walk(input int count);
    int push_pct;
    logic signed [31:0] word;
    for (int i = 0; i < count; i++) begin
      push_pct = (stack_fill == DEPTH) ? 30 : (stack_fill == 0) ? 70 : 55;
      word = ($urandom_range(0, 2) == 0) ? pick_word() : $urandom_range(1, 3);
      if ($urandom_range(0, 99) < push_pct) send_request(REQ_PUSH, word);
      else send_request(REQ_POP, word);
      pace();
      if (i % 110 == 109) idle_until_drained();
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d fill %0d", out_data.status,
               out_data.fill_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          fail_count++;
        end
        if (out_data.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, got %0d", want.popped_value,
                 out_data.popped_value);
          fail_count++;
        end
        if (out_data.fill_count !== want.fill_count) begin
          $error("fill_count: expected %0d, got %0d", want.fill_count,
                 out_data.fill_count);
          fail_count++;
        end
        if (out_data.is_palindrome !== want.is_palindrome) begin
          $error("is_palindrome: expected %0d, got %0d", want.is_palindrome,
                 out_data.is_palindrome);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_data     = '0;
    stack_fill  = 0;
    fail_count  = 0;
    cycle_count = 0;
    burst_left  = 0;
    n_push      = 0;
    n_pop       = 0;
    n_overflow  = 0;
    n_underflow = 0;
    n_mirror    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pop_empty();
    test_fill_mirror();
    test_push_full();
    test_drain();
    idle_until_drained();
    test_mirror_blocks(34);
    idle_until_drained();
    test_random_walk(330);
    idle_until_drained();
    repeat (DEPTH / 2 + 8) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d overflows, %0d underflows",
             n_push, n_pop, n_overflow, n_underflow);
    $display("%0d results with symmetric contents of depth two or more", n_mirror);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
